>>> rtl/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Action codes, controller states and the command/status words that link
// the controller to the datapath.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_REGION = 2'd1;
  localparam logic [1:0] ACT_ALLOC  = 2'd2;

  localparam logic [31:0] TYPE_USABLE = 32'd1;

  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 27;

  typedef enum logic [3:0] {
    S_RST_SWEEP,
    S_IDLE,
    S_CLR_SWEEP,
    S_REG_STOP,
    S_REG_CHECK,
    S_REG_WRITE,
    S_ALLOC_CHECK,
    S_ALLOC_TEST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;      // capture the region, restart the walk, clear result
    logic clr_limit;
    logic set_limit;
    logic wr_fill;   // write an all-reserved word
    logic rd;
    logic reg_wr;    // write word with region pages freed
    logic alloc_wr;  // write word with lowest free page taken
    logic step;      // advance to next word
  } cmd_t;

  typedef struct packed {
    logic type_ok;
    logic sweep_last;
    logic reg_more;
    logic alloc_more;
    logic word_full;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/bpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap page allocator controller
// Sequences the fill sweep, region walk and allocation scan.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       action,
  input  wire bpa_pkg::status_t status,
  output bpa_pkg::cmd_t         cmd,
  output logic                  busy,
  output logic                  done
);
  import bpa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_RST_SWEEP: begin
        if (status.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (action)
            ACT_CLEAR:  state_next = S_CLR_SWEEP;
            ACT_REGION: state_next = status.type_ok ? S_REG_STOP : S_DONE;
            ACT_ALLOC:  state_next = S_ALLOC_CHECK;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_CLR_SWEEP: begin
        if (status.sweep_last) state_next = S_DONE;
      end
      S_REG_STOP:    state_next = S_REG_CHECK;
      S_REG_CHECK:   state_next = status.reg_more ? S_REG_WRITE : S_DONE;
      S_REG_WRITE:   state_next = S_REG_CHECK;
      S_ALLOC_CHECK: state_next = status.alloc_more ? S_ALLOC_TEST : S_DONE;
      S_ALLOC_TEST:  state_next = status.word_full ? S_ALLOC_CHECK : S_DONE;
      S_DONE:        state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_RST_SWEEP, S_CLR_SWEEP: begin
        cmd.wr_fill = 1'b1;
        cmd.step    = 1'b1;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load      = 1'b1;
          cmd.clr_limit = (action == ACT_CLEAR);
        end
      end
      S_REG_STOP:  cmd.set_limit = 1'b1;
      S_REG_CHECK: cmd.rd = status.reg_more;
      S_REG_WRITE: begin
        cmd.reg_wr = 1'b1;
        cmd.step   = 1'b1;
      end
      S_ALLOC_CHECK: cmd.rd = status.alloc_more;
      S_ALLOC_TEST: begin
        cmd.step     = status.word_full;
        cmd.alloc_wr = !status.word_full;
      end
      S_DONE: done = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/bpa_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap page allocator datapath
// Page bitmap memory, word walker, region bounds, free-page search, result.
// ----------------------------------------------------------------------------
module bpa_dpath #(
  parameter int MAX_PAGES = 32768,
  parameter int WORD_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire bpa_pkg::cmd_t          cmd,
  input  wire logic [31:0]            region_type,
  input  wire logic [63:0]            region_base,
  input  wire logic [63:0]            region_length,
  output bpa_pkg::status_t            status,
  output logic [bpa_pkg::ADDR_W-1:0]  page_address,
  output logic                        found
);
  import bpa_pkg::*;

  localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LIM_W = $clog2(MAX_PAGES + 1);
  localparam int PB_W  = $clog2(MAX_PAGES + 2 * WORD_BITS + 1);
  localparam int CNT_W = $clog2(WORD_BITS + 1);
  localparam int IDX_W = $clog2(WORD_BITS);
  localparam int FP_W  = 64 - PAGE_SHIFT;

  localparam logic [WORD_BITS-1:0] ALL_ONES = '1;
  localparam logic [PB_W-1:0]      WB_PB    = PB_W'(WORD_BITS);
  localparam logic [FP_W-1:0]      MAX_FP   = FP_W'(MAX_PAGES);
  localparam logic [CNT_W-1:0]     WB_CNT   = CNT_W'(WORD_BITS);

  function automatic logic [WORD_BITS-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [WORD_BITS:0] t;
    t = ~({(WORD_BITS + 1){1'b1}} << n);
    return t[WORD_BITS-1:0];
  endfunction

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] wr_data;
  logic                 wr_en;

  logic [WA_W-1:0]  w;
  logic [PB_W-1:0]  pb;
  logic [FP_W-1:0]  first_page;
  logic [FP_W-1:0]  last_page;
  logic [LIM_W-1:0] stop_page;
  logic             empty;
  logic [LIM_W-1:0] page_limit;

  logic [63:0]      end_sum;
  logic [63:0]      first_sum;
  logic [LIM_W-1:0] stop_next;
  logic [PB_W-1:0]  pb_plus;
  logic [PB_W-1:0]  first_pb;
  logic [PB_W-1:0]  stop_pb;
  logic [PB_W-1:0]  lo_diff;
  logic [CNT_W-1:0] lo_cnt;
  logic [CNT_W-1:0] hi_cnt;
  logic [WORD_BITS-1:0] free_mask;
  logic [WORD_BITS-1:0] take_bit;
  logic [IDX_W-1:0]     take_idx;
  logic [PB_W-1:0]      take_page;
  logic [63:0]          take_addr;

  assign end_sum   = region_base + region_length;
  assign first_sum = region_base + 64'd4095;
  assign stop_next = (last_page < MAX_FP) ? last_page[LIM_W-1:0] : LIM_W'(MAX_PAGES);

  assign pb_plus  = pb + WB_PB;
  assign first_pb = PB_W'(first_page[LIM_W-1:0]);
  assign stop_pb  = PB_W'(stop_page);

  // Bits [lo, hi) of the current word fall inside the region
  always_comb begin
    lo_diff = (first_pb > pb) ? (first_pb - pb) : '0;
    lo_cnt  = (lo_diff >= WB_PB) ? WB_CNT : lo_diff[CNT_W-1:0];
    hi_cnt  = (stop_pb >= pb_plus) ? WB_CNT : CNT_W'(stop_pb - pb);
    free_mask = low_mask(hi_cnt) & ~low_mask(lo_cnt);
  end

  // Lowest clear bit of the word read
  always_comb begin
    take_bit = ~rd_data & (rd_data + WORD_BITS'(1));
    take_idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (take_bit[b]) take_idx = take_idx | IDX_W'(b);
    end
    take_page = pb + PB_W'(take_idx);
    take_addr = 64'(take_page) << PAGE_SHIFT;
  end

  always_comb begin
    wr_en   = cmd.wr_fill | cmd.reg_wr | cmd.alloc_wr;
    wr_data = ALL_ONES;
    if (cmd.reg_wr)   wr_data = rd_data & ~free_mask;
    if (cmd.alloc_wr) wr_data = rd_data | take_bit;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[w] <= wr_data;
    if (cmd.rd) rd_data <= mem[w];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w          <= '0;
      pb         <= '0;
      page_limit <= '0;
      found      <= 1'b0;
    end else begin
      if (cmd.load) begin
        w     <= '0;
        pb    <= '0;
        found <= 1'b0;
      end else if (cmd.step) begin
        w  <= w + WA_W'(1);
        pb <= pb_plus;
      end
      if (cmd.clr_limit) page_limit <= '0;
      if (cmd.set_limit) page_limit <= stop_next;
      if (cmd.alloc_wr)  found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_page   <= first_sum[63:PAGE_SHIFT];
      last_page    <= end_sum[63:PAGE_SHIFT];
      page_address <= '0;
    end
    if (cmd.set_limit) begin
      stop_page <= stop_next;
      empty     <= first_page >= FP_W'(stop_next);
    end
    if (cmd.alloc_wr) page_address <= take_addr[ADDR_W-1:0];
  end

  assign status.type_ok    = (region_type == TYPE_USABLE);
  assign status.sweep_last = (w == WA_W'(MAP_WORDS - 1));
  assign status.reg_more   = !empty && (pb < stop_pb);
  assign status.alloc_more = (pb_plus <= PB_W'(page_limit));
  assign status.word_full  = (rd_data == ALL_ONES);

endmodule
`default_nettype wire

>>> rtl/bitmap_page_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap page allocator
// One bit per 4 KiB page held in an on-chip word memory, plus a page limit.
// ----------------------------------------------------------------------------
// Use: drive action and the region fields and raise start while busy is low;
// the command word is taken at that edge. Every command returns one result:
// done is high for a single cycle with page_address and found valid. The
// receiver cannot stall, so the result must be taken in that cycle.
// Commands:
//   clear  - mark every page reserved, zero the limit. Sweeps the bitmap
//            one word a cycle.
//   region - usable entries free the whole pages inside base..base+length
//            and set the limit. Walks every word below the end page with a
//            read then a write, but no word when no whole page lies inside
//            the region. Other types leave the bitmap and the limit unchanged.
//   alloc  - scans whole words below the limit, reading then testing each
//            word, and takes the lowest free page.
// Single-port bitmap memory bounds the rate: one word per read-modify-write.
// After reset the bitmap, MAP_WORDS words (1024 at the defaults), is swept to
// all reserved; busy stays high during the sweep.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core #(
  parameter int MAX_PAGES = 32768,
  parameter int WORD_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [1:0]            action,
  input  wire logic [31:0]           region_type,
  input  wire logic [63:0]           region_base,
  input  wire logic [63:0]           region_length,
  output logic                       busy,
  output logic                       done,
  output logic [bpa_pkg::ADDR_W-1:0] page_address,
  output logic                       found
);
  import bpa_pkg::*;

  cmd_t    cmd;
  status_t status;

  bpa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bpa_dpath #(
    .MAX_PAGES (MAX_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .region_type   (region_type),
    .region_base   (region_base),
    .region_length (region_length),
    .status        (status),
    .page_address  (page_address),
    .found         (found)
  );

endmodule
`default_nettype wire
